// ----- rtl/tfsq_pkg.sv -----
// shared beat types and action codes for the timed frame schedule queue
`default_nettype none

package tfsq_pkg;

  localparam int TIME_W  = 48;
  localparam int FRAME_W = 64;
  localparam int PEND_W  = 7;

  // action codes of an input beat
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [TIME_W-1:0]  command_time;
    logic [FRAME_W-1:0] frame_in;
    logic [TIME_W-1:0]  now_time;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic               frame_valid;
    logic               fired;
    logic [FRAME_W-1:0] frame_out;
    logic [PEND_W-1:0]  pending;
    logic [TIME_W-1:0]  last_fired_time;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/tfsq_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module tfsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/timed_frame_schedule_queue_unit.sv -----
// Timestamp-sorted queue of timed frames held in a circular ram.
//
// Input channel in_valid / in_stall / in_data carries add, tick and clear
// beats; output channel out_valid / out_stall / out_data returns exactly one
// result beat per input beat, in order. in_stall is low only while the
// sequencer is idle, so one beat is worked on at a time.
// An add walks the queue from its tail toward its head with the time
// comparator, moving each entry that is not earlier up one slot, one entry
// per cycle, then writes the new entry in S_PUT. A tick walks from the head
// while entries are due, one per cycle, then advances the head pointer.
// Clear, unused codes, a refused add and a tick on an empty queue go
// straight to S_OUT, where the result is loaded into the output register.
// A finished result sits in the output register; the next beat is taken
// while it waits. If out_stall holds the register full when a new result is
// done, the sequencer waits and in_stall stays high.
// Synchronous reset empties the queue and drops the held frame; no ram
// clearing pass is needed since only entries below the fill count are read.
`default_nettype none

module timed_frame_schedule_queue_unit #(
  parameter int QUEUE_DEPTH = 64,
  parameter int CHANNELS    = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire tfsq_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tfsq_pkg::out_t      out_data
);

  localparam int FW    = 8 * CHANNELS;
  localparam int TW    = tfsq_pkg::TIME_W;
  localparam int RW    = TW + FW;
  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_PUT  = 5'b00100,
    S_TICK = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t            state;
  logic [AW-1:0]     head;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  put_pos;
  logic [FW-1:0]     held_frame;
  logic              has_fired;
  logic [TW-1:0]     fired_time;
  logic [1:0]        rsp_action;
  logic              rsp_accepted;
  logic              rsp_fired;
  logic [TW-1:0]     item_time;
  logic [FW-1:0]     item_frame;
  logic [TW-1:0]     item_now;

  logic              wr_en;
  logic [CNT_W-1:0]  wr_log;
  logic [RW-1:0]     wr_data;
  logic [CNT_W-1:0]  rd_log;
  logic [RW-1:0]     rd_data;
  logic [TW-1:0]     rd_time;
  logic [FW-1:0]     rd_frame;
  logic              in_take;
  logic              out_free;
  logic              add_hit;
  logic              tick_hit;
  logic [CNT_W-1:0]  tick_due;
  logic              tick_done;
  tfsq_pkg::out_t    rsp_beat;

  // logical queue slot to physical ram address, wrapping at the depth
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CNT_W-1:0] slot);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(slot);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return AW'(sum);
  endfunction

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign rd_time  = rd_data[RW-1:FW];
  assign rd_frame = rd_data[FW-1:0];

  // time comparators: add keeps walking while stored time is not earlier
  assign add_hit   = (rd_time < item_time);
  assign tick_hit  = (rd_time <= item_now);
  assign tick_due  = tick_hit ? idx + CNT_W'(1) : idx;
  assign tick_done = !tick_hit || (idx + CNT_W'(1) == count);

  // read slot selection
  always_comb begin
    case (state)
      S_IDLE:  rd_log = (in_data.action == tfsq_pkg::ACT_ADD) ? count - CNT_W'(1)
                                                               : '0;
      S_ADD:   rd_log = idx - CNT_W'(1);
      S_TICK:  rd_log = idx + CNT_W'(1);
      default: rd_log = '0;
    endcase
  end

  // write slot selection
  always_comb begin
    wr_en   = 1'b0;
    wr_log  = put_pos;
    wr_data = {item_time, item_frame};
    case (state)
      S_ADD: begin
        if (!add_hit) begin
          wr_en   = 1'b1;
          wr_log  = idx + CNT_W'(1);
          wr_data = rd_data;
        end
      end
      S_PUT: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  tfsq_ram #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (phys(head, wr_log)),
    .wr_data (wr_data),
    .rd_addr (phys(head, rd_log)),
    .rd_data (rd_data)
  );

  // result beat from the state after the item
  always_comb begin
    rsp_beat.accepted        = rsp_accepted;
    rsp_beat.frame_valid     = (rsp_action == tfsq_pkg::ACT_TICK) && has_fired;
    rsp_beat.fired           = rsp_fired;
    rsp_beat.frame_out       = rsp_beat.frame_valid ? tfsq_pkg::FRAME_W'(held_frame) : '0;
    rsp_beat.pending         = tfsq_pkg::PEND_W'(count);
    rsp_beat.last_fired_time = fired_time;
  end

  // item payload capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_time  <= in_data.command_time;
      item_frame <= in_data.frame_in[FW-1:0];
      item_now   <= in_data.now_time;
      rsp_action <= in_data.action;
    end
  end

  // sequencer and queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      count        <= '0;
      idx          <= '0;
      put_pos      <= '0;
      held_frame   <= '0;
      has_fired    <= 1'b0;
      fired_time   <= '0;
      rsp_accepted <= 1'b0;
      rsp_fired    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            rsp_accepted <= 1'b0;
            rsp_fired    <= 1'b0;
            state        <= S_OUT;
            case (in_data.action)
              tfsq_pkg::ACT_ADD: begin
                if (count == CNT_W'(QUEUE_DEPTH)) begin
                  state <= S_OUT;
                end else if (count == '0) begin
                  put_pos <= '0;
                  state   <= S_PUT;
                end else begin
                  idx   <= count - CNT_W'(1);
                  state <= S_ADD;
                end
              end
              tfsq_pkg::ACT_TICK: begin
                if (count != '0) begin
                  idx   <= '0;
                  state <= S_TICK;
                end
              end
              tfsq_pkg::ACT_CLEAR: begin
                count      <= '0;
                head       <= '0;
                has_fired  <= 1'b0;
                fired_time <= '0;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_ADD: begin
          // insert point is just above the first earlier entry
          if (add_hit) begin
            put_pos <= idx + CNT_W'(1);
            state   <= S_PUT;
          end else if (idx == '0) begin
            put_pos <= '0;
            state   <= S_PUT;
          end else begin
            idx <= idx - CNT_W'(1);
          end
        end
        S_PUT: begin
          count        <= count + CNT_W'(1);
          rsp_accepted <= 1'b1;
          state        <= S_OUT;
        end
        S_TICK: begin
          if (tick_hit) begin
            held_frame <= rd_frame;
            fired_time <= rd_time;
            has_fired  <= 1'b1;
            rsp_fired  <= 1'b1;
          end
          if (tick_done) begin
            head  <= phys(head, tick_due);
            count <= count - tick_due;
            state <= S_OUT;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_data <= rsp_beat;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the timed frame schedule queue unit
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH        = 64;
  localparam int CHANNELS     = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 200;
  localparam int DIR_ROWS     = 22;

  // code three carries no operation
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [tfsq_pkg::TIME_W-1:0]  T_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [tfsq_pkg::FRAME_W-1:0] F_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [tfsq_pkg::FRAME_W-1:0] CHAN_MASK = F_ONES >> (64 - 8 * CHANNELS);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  tfsq_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tfsq_pkg::out_t out_data;

  int fail_count    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // results still owed by the block, oldest first
  tfsq_pkg::out_t sched_expected [$];

  // shadow copy of the schedule
  logic [tfsq_pkg::TIME_W-1:0]  slot_time  [DEPTH];
  logic [tfsq_pkg::FRAME_W-1:0] slot_frame [DEPTH];
  int                           slot_count = 0;
  logic [tfsq_pkg::FRAME_W-1:0] held_frame = '0;
  bit                           has_fired  = 1'b0;
  logic [tfsq_pkg::TIME_W-1:0]  fired_time = '0;

  // running millisecond clock for random ticks
  logic [tfsq_pkg::TIME_W-1:0]  clock_ms = '0;

  typedef struct {
    logic [1:0]                   act;
    logic [tfsq_pkg::TIME_W-1:0]  ctime;
    logic [tfsq_pkg::FRAME_W-1:0] frame;
    logic [tfsq_pkg::TIME_W-1:0]  now_ms;
    bit                           typed;
    logic                         acc;
    logic                         fv;
    logic                         fr;
    logic [tfsq_pkg::FRAME_W-1:0] fout;
    logic [tfsq_pkg::PEND_W-1:0]  pend;
    logic [tfsq_pkg::TIME_W-1:0]  lft;
  } dir_row_t;

  // directed rows: act, command time, frame, now, typed, then the typed result
  dir_row_t dir_table [DIR_ROWS] = '{
    '{tfsq_pkg::ACT_TICK,  0,     0,                     0,     1, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_CLEAR, 0,     0,                     0,     1, 0, 0, 0, 0, 0, 0},
    '{ACT_NONE,            T_MAX, F_ONES,                T_MAX, 1, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_ADD,   T_MAX, F_ONES,                0,     1, 1, 0, 0, 0, 1, 0},
    '{tfsq_pkg::ACT_ADD,   0,     0,                     0,     1, 1, 0, 0, 0, 2, 0},
    '{tfsq_pkg::ACT_ADD,   5,     64'h0706_0504_0302_0100, 0,   1, 1, 0, 0, 0, 3, 0},
    '{tfsq_pkg::ACT_ADD,   5,     64'h8080_8080_8080_8080, 0,   1, 1, 0, 0, 0, 4, 0},
    '{tfsq_pkg::ACT_TICK,  0,     0,                     0,     1, 0, 1, 1, 0, 3, 0},
    '{tfsq_pkg::ACT_TICK,  0,     0,                     4,     0, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_TICK,  0,     0,                     5,     0, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_ADD,   3,     64'h1234_5678_9ABC_DEF0, 0,   0, 0, 0, 0, 0, 0, 0},
    '{ACT_NONE,            0,     0,                     0,     0, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_TICK,  0,     0,                     3,     0, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_TICK,  0,     0,                     T_MAX, 0, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_TICK,  0,     0,                     T_MAX, 0, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_CLEAR, 0,     0,                     0,     1, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_TICK,  0,     0,                     T_MAX, 1, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_ADD,   1,     64'h5555_5555_5555_5555, 0,   1, 1, 0, 0, 0, 1, 0},
    '{tfsq_pkg::ACT_ADD,   1,     64'hAAAA_AAAA_AAAA_AAAA, 0,   1, 1, 0, 0, 0, 2, 0},
    '{tfsq_pkg::ACT_TICK,  0,     0,                     1,     0, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_ADD,   48'h8000_0000_0000, 64'hC3C3_0F0F_3C3C_F0F0, 0,
      0, 0, 0, 0, 0, 0, 0},
    '{tfsq_pkg::ACT_CLEAR, 0,     0,                     0,     1, 0, 0, 0, 0, 0, 0}
  };

  timed_frame_schedule_queue_unit #(
    .QUEUE_DEPTH(DEPTH),
    .CHANNELS(CHANNELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [tfsq_pkg::TIME_W-1:0] rand_ms();
    return {16'($urandom_range(16'hFFFF)), 32'($urandom)};
  endfunction

  function automatic logic [tfsq_pkg::FRAME_W-1:0] rand_frame();
    return {32'($urandom), 32'($urandom)};
  endfunction

  // work out the result of one beat and advance the shadow schedule
  task automatic sched_step(input tfsq_pkg::in_t b, output tfsq_pkg::out_t r);
    int pos;
    int due;
    int i;
    r = '0;
    case (b.action)
      tfsq_pkg::ACT_ADD: begin
        if (slot_count < DEPTH) begin
          pos = 0;
          while (pos < slot_count && slot_time[pos] < b.command_time) pos++;
          for (i = slot_count; i > pos; i--) begin
            slot_time[i]  = slot_time[i-1];
            slot_frame[i] = slot_frame[i-1];
          end
          slot_time[pos]  = b.command_time;
          slot_frame[pos] = b.frame_in & CHAN_MASK;
          slot_count++;
          r.accepted = 1'b1;
        end
      end
      tfsq_pkg::ACT_TICK: begin
        due = 0;
        while (due < slot_count && slot_time[due] <= b.now_time) due++;
        if (due > 0) begin
          held_frame = slot_frame[due-1];
          fired_time = slot_time[due-1];
          has_fired  = 1'b1;
          for (i = due; i < slot_count; i++) begin
            slot_time[i-due]  = slot_time[i];
            slot_frame[i-due] = slot_frame[i];
          end
          slot_count -= due;
          r.fired = 1'b1;
        end
        if (has_fired) begin
          r.frame_valid = 1'b1;
          r.frame_out   = held_frame & CHAN_MASK;
        end
      end
      tfsq_pkg::ACT_CLEAR: begin
        slot_count = 0;
        has_fired  = 1'b0;
        fired_time = '0;
      end
      default: ;
    endcase
    r.pending         = tfsq_pkg::PEND_W'(slot_count);
    r.last_fired_time = fired_time;
  endtask

  // record the expectation, then hold the beat until it is taken
  task automatic send_beat(input tfsq_pkg::in_t b, input tfsq_pkg::out_t want);
    sched_expected.push_back(want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic apply_beat(input tfsq_pkg::in_t b);
    tfsq_pkg::out_t want;
    sched_step(b, want);
    send_beat(b, want);
  endtask

  // random sequences: add bursts, tick runs, raw beats, clears and noise
  task automatic run_random(input int n_items);
    int             made;
    int             kind;
    int             k;
    int             j;
    tfsq_pkg::in_t  b;
    made = 0;
    while (made < n_items) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // add burst, now and then running past a full queue
        if ($urandom_range(3) == 0) k = DEPTH - slot_count + $urandom_range(1, 3);
        else k = $urandom_range(1, 12);
        for (j = 0; j < k; j++) begin
          b = '0;
          b.action = tfsq_pkg::ACT_ADD;
          if ($urandom_range(1) == 0)
            b.command_time = clock_ms + 48'($urandom_range(0, 12)) * 4;
          else
            b.command_time = clock_ms + 48'($urandom_range(0, 500)) - 48'd20;
          b.frame_in = rand_frame();
          b.now_time = rand_ms();
          apply_beat(b);
          made++;
        end
      end else if (kind < 75) begin
        // run of ticks with the clock moving forward
        k = $urandom_range(1, 6);
        for (j = 0; j < k; j++) begin
          b = '0;
          b.action = tfsq_pkg::ACT_TICK;
          clock_ms = clock_ms + 48'($urandom_range(0, 60));
          b.now_time     = clock_ms;
          b.command_time = rand_ms();
          b.frame_in     = rand_frame();
          apply_beat(b);
          made++;
        end
      end else if (kind < 85) begin
        // add or tick with every field at random
        b.action       = $urandom_range(1) ? tfsq_pkg::ACT_ADD : tfsq_pkg::ACT_TICK;
        b.command_time = rand_ms();
        b.frame_in     = rand_frame();
        b.now_time     = rand_ms();
        apply_beat(b);
        made++;
      end else if (kind < 92) begin
        b = '0;
        b.action = tfsq_pkg::ACT_CLEAR;
        b.frame_in = rand_frame();
        apply_beat(b);
        made++;
      end else begin
        // unused code, does not count
        b.action       = ACT_NONE;
        b.command_time = rand_ms();
        b.frame_in     = rand_frame();
        b.now_time     = rand_ms();
        apply_beat(b);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // result beat check against the oldest expectation
  always @(posedge clk) begin
    tfsq_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (sched_expected.size() == 0) begin
        $error("result beat arrived with nothing expected");
        fail_count++;
      end else begin
        want = sched_expected.pop_front();
        check_field("accepted", want.accepted, out_data.accepted);
        check_field("frame_valid", want.frame_valid, out_data.frame_valid);
        check_field("fired", want.fired, out_data.fired);
        check_field("frame_out", want.frame_out, out_data.frame_out);
        check_field("pending", want.pending, out_data.pending);
        check_field("last_fired_time", want.last_fired_time, out_data.last_fired_time);
      end
    end
  end

  // main sequence
  initial begin
    tfsq_pkg::in_t  beat;
    tfsq_pkg::out_t want;
    dir_row_t       r;

    send_idle_pct = 19;
    recv_idle_pct = 62;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    foreach (dir_table[i]) begin
      r = dir_table[i];
      beat.action       = r.act;
      beat.command_time = r.ctime;
      beat.frame_in     = r.frame;
      beat.now_time     = r.now_ms;
      sched_step(beat, want);
      if (r.typed)
        want = '{accepted: r.acc, frame_valid: r.fv, fired: r.fr, frame_out: r.fout,
                 pending: r.pend, last_fired_time: r.lft};
      send_beat(beat, want);
    end

    // random part over three idling mixes
    run_random(250);
    send_idle_pct = 62;
    recv_idle_pct = 19;
    run_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(250);

    in_valid <= 1'b0;
    while (sched_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
